[hw/rtl/assert_macros.svh]
// Assertion macros shared by the radix-to-symbols RTL.
// Depends on nothing; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[hw/rtl/srts_pkg.sv]
// Package for the signed radix-to-symbols block: widths, character constants,
// register indexes, state and status types, and the symbol lookup function.
// Depends on nothing.
package srts_pkg;

  localparam int MAG_W       = 32;
  localparam int DIG_W       = 4;
  localparam int RADIX_W     = 5;
  localparam int SYM_W       = 8;
  localparam int SYM_SLOTS   = 16;
  localparam int NUM_WORDS   = 4;
  localparam int STACK_DEPTH = 32;
  localparam int STACK_AW    = 5;
  localparam int CNT_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int DIV_BITS    = 8;
  localparam int DIV_CYCLES  = MAG_W / DIV_BITS;
  localparam int DIV_STEP_W  = $clog2(DIV_CYCLES);

  localparam logic [SYM_W-1:0]   CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0]   CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0]   CH_LO    = 8'd32;
  localparam logic [SYM_W-1:0]   CH_HI    = 8'd127;
  localparam logic [RADIX_W-1:0] MIN_LEN  = 5'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SYM_0_3   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_4_7   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_8_11  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_12_15 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALEN      = 3'd4;

  localparam logic [31:0]        RST_SYM_0_3   = 32'd858927408;
  localparam logic [31:0]        RST_SYM_4_7   = 32'd926299444;
  localparam logic [31:0]        RST_SYM_8_11  = 32'd1650538808;
  localparam logic [31:0]        RST_SYM_12_15 = 32'd1717920867;
  localparam logic [RADIX_W-1:0] RST_ALEN      = 5'd16;

  typedef logic [NUM_WORDS-1:0][31:0] alph_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } srts_state_t;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [SYM_W-1:0] sym_at(alph_t w, logic [DIG_W-1:0] k);
    return w[k[3:2]][{k[1:0], 3'b000} +: SYM_W];
  endfunction

endpackage

[hw/rtl/srts_alpha_chk.sv]
// Alphabet validator: steps through the symbols in use, one per cycle, checking the
// length bound, range, sign characters and duplicates. Depends on srts_pkg.
module srts_alpha_chk #(
  parameter int LEN_BOUND = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  srts_pkg::alph_t               alph,
  input  logic [srts_pkg::RADIX_W-1:0]  alen,
  output srts_pkg::chk_stat_t           stat
);

  logic                         busy_r;
  logic                         busy_nxt;
  logic [srts_pkg::DIG_W-1:0]   idx_r;
  logic [srts_pkg::DIG_W-1:0]   idx_nxt;
  srts_pkg::chk_stat_t          stat_r;
  srts_pkg::chk_stat_t          stat_nxt;
  logic [srts_pkg::SYM_W-1:0]   cur;
  logic                         len_bad;
  logic                         ch_bad;
  logic                         dup;
  logic                         at_last;

  always_comb begin
    cur     = srts_pkg::sym_at(alph, idx_r);
    len_bad = (alen < srts_pkg::MIN_LEN) ||
              (alen > srts_pkg::RADIX_W'(LEN_BOUND));
    ch_bad  = (cur < srts_pkg::CH_LO) || (cur >= srts_pkg::CH_HI) ||
              (cur == srts_pkg::CH_PLUS) || (cur == srts_pkg::CH_MINUS);
    dup     = 1'b0;
    for (int j = 0; j < srts_pkg::SYM_SLOTS; j++) begin
      if ((srts_pkg::RADIX_W'(j) > {1'b0, idx_r}) && (srts_pkg::RADIX_W'(j) < alen) &&
          (srts_pkg::sym_at(alph, srts_pkg::DIG_W'(j)) == cur)) begin
        dup = 1'b1;
      end
    end
    at_last = ({1'b0, idx_r} == (alen - 5'd1));
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    stat_nxt = '0;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (busy_r) begin
      if (len_bad || ch_bad || dup) begin
        busy_nxt      = 1'b0;
        stat_nxt.done = 1'b1;
      end else if (at_last) begin
        busy_nxt      = 1'b0;
        stat_nxt.done = 1'b1;
        stat_nxt.ok   = 1'b1;
      end else begin
        idx_nxt = idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      stat_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign stat = stat_r;

endmodule

[hw/rtl/srts_div_unit.sv]
// Shared divider: restoring division of a 32-bit magnitude by the radix,
// eight quotient bits per cycle. Depends on srts_pkg.
module srts_div_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [srts_pkg::MAG_W-1:0]    dividend,
  input  logic [srts_pkg::RADIX_W-1:0]  divisor,
  output srts_pkg::div_stat_t           stat,
  output logic [srts_pkg::MAG_W-1:0]    quotient,
  output logic [srts_pkg::DIG_W-1:0]    remainder
);

  logic [srts_pkg::MAG_W-1:0]      quo_r;
  logic [srts_pkg::MAG_W-1:0]      quo_nxt;
  logic [srts_pkg::DIG_W-1:0]      rem_r;
  logic [srts_pkg::DIG_W-1:0]      rem_nxt;
  logic [srts_pkg::RADIX_W-1:0]    dvsr_r;
  logic [srts_pkg::DIV_STEP_W-1:0] step_r;
  srts_pkg::div_stat_t             stat_r;
  logic [srts_pkg::MAG_W-1:0]      q_sh;
  logic [srts_pkg::DIG_W-1:0]      r_sh;

  always_comb begin
    logic [srts_pkg::RADIX_W-1:0] t;
    q_sh = quo_r;
    r_sh = rem_r;
    for (int k = 0; k < srts_pkg::DIV_BITS; k++) begin
      t    = {r_sh, q_sh[srts_pkg::MAG_W-1]};
      q_sh = {q_sh[srts_pkg::MAG_W-2:0], 1'b0};
      if (t >= dvsr_r) begin
        t       = t - dvsr_r;
        q_sh[0] = 1'b1;
      end
      r_sh = t[srts_pkg::DIG_W-1:0];
    end
  end

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (stat_r.busy) begin
      quo_nxt = q_sh;
      rem_nxt = r_sh;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvsr_r <= divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_r <= '0;
      step_r <= '0;
    end else if (start) begin
      stat_r.busy <= 1'b1;
      stat_r.done <= 1'b0;
      step_r      <= '0;
    end else if (stat_r.busy) begin
      step_r <= step_r + srts_pkg::DIV_STEP_W'(1);
      if (step_r == srts_pkg::DIV_STEP_W'(srts_pkg::DIV_CYCLES - 1)) begin
        stat_r.busy <= 1'b0;
        stat_r.done <= 1'b1;
      end
    end else begin
      stat_r.done <= 1'b0;
    end
  end

  assign stat      = stat_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[hw/rtl/signed_radix_to_symbols.sv]
// Signed radix-to-symbols converter, top level: configuration registers,
// sequencer, digit stack and output register.
// Depends on srts_pkg, srts_alpha_chk, srts_div_unit and assert_macros.svh.
//
// Usage: in_tdata carries one signed 32-bit value per transaction. The block
// writes its representation in radix alphabet_length as a run of symbol bytes
// on out_tdata, most significant digit first, with a leading '-' for negative
// values; out_tlast marks the final symbol of the run. The cfg_ port sets the
// 16 alphabet bytes and the length; write it only while the block is idle.
// An alphabet that fails validation yields no output for that value.
// Sequence: after acceptance, validation steps through the symbols in use
// (up to 16), each digit takes one pass of the shared divider (8 quotient
// bits per cycle), then symbols leave at one per cycle while out_tready is
// high. in_tready is high only between values.
// The output register holds a symbol while out_tready is low; the sequencer
// waits on it. Reset restores the alphabet "0123456789abcdef" and clears the
// sequencer and output valid.
`include "assert_macros.svh"

module signed_radix_to_symbols #(
  parameter int MAX_BASE = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // [31:0] value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [7:0] symbol
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [srts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_wdata
);

  localparam int LEN_BOUND = (MAX_BASE < srts_pkg::SYM_SLOTS) ? MAX_BASE :
                             srts_pkg::SYM_SLOTS;

  srts_pkg::alph_t                   alph_r;
  logic [srts_pkg::RADIX_W-1:0]      alen_r;
  srts_pkg::srts_state_t             state_r;
  srts_pkg::srts_state_t             state_nxt;
  logic [srts_pkg::MAG_W-1:0]        mag_r;
  logic                              sign_r;
  logic                              sign_nxt;
  logic [srts_pkg::CNT_W-1:0]        cnt_r;
  logic [srts_pkg::CNT_W-1:0]        cnt_nxt;
  logic [srts_pkg::DIG_W-1:0]        stack_r [srts_pkg::STACK_DEPTH];
  logic                              stack_we;
  logic [srts_pkg::STACK_AW-1:0]     rd_idx;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [srts_pkg::SYM_W-1:0]        out_sym_r;
  logic [srts_pkg::SYM_W-1:0]        out_sym_nxt;
  logic                              out_last_r;
  logic                              out_last_nxt;
  logic                              out_free;
  logic                              in_acc;
  logic                              chk_start;
  logic                              div_start;
  logic [srts_pkg::MAG_W-1:0]        div_dividend;
  srts_pkg::chk_stat_t               chk_stat;
  srts_pkg::div_stat_t               div_stat;
  logic [srts_pkg::MAG_W-1:0]        div_quo;
  logic [srts_pkg::DIG_W-1:0]        div_rem;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alph_r[0] <= srts_pkg::RST_SYM_0_3;
      alph_r[1] <= srts_pkg::RST_SYM_4_7;
      alph_r[2] <= srts_pkg::RST_SYM_8_11;
      alph_r[3] <= srts_pkg::RST_SYM_12_15;
      alen_r    <= srts_pkg::RST_ALEN;
    end else if (cfg_we) begin
      case (cfg_index)
        srts_pkg::CFG_SYM_0_3:   alph_r[0] <= cfg_wdata;
        srts_pkg::CFG_SYM_4_7:   alph_r[1] <= cfg_wdata;
        srts_pkg::CFG_SYM_8_11:  alph_r[2] <= cfg_wdata;
        srts_pkg::CFG_SYM_12_15: alph_r[3] <= cfg_wdata;
        srts_pkg::CFG_ALEN:      alen_r    <= cfg_wdata[srts_pkg::RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  srts_alpha_chk #(
    .LEN_BOUND(LEN_BOUND)
  ) u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (chk_start),
    .alph  (alph_r),
    .alen  (alen_r),
    .stat  (chk_stat)
  );

  srts_div_unit u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (alen_r),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_tready    = (state_r == srts_pkg::ST_IDLE);
  assign in_acc       = in_tvalid && in_tready;
  assign chk_start    = in_acc;
  assign out_free     = !out_valid_r || out_tready;
  assign div_dividend = (state_r == srts_pkg::ST_CHECK) ? mag_r : div_quo;
  assign rd_idx       = srts_pkg::STACK_AW'(cnt_r - 6'd1);

  always_comb begin
    state_nxt     = state_r;
    sign_nxt      = sign_r;
    cnt_nxt       = cnt_r;
    div_start     = 1'b0;
    stack_we      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      srts_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = srts_pkg::ST_CHECK;
          sign_nxt  = in_tdata[31];
          cnt_nxt   = '0;
        end
      end
      srts_pkg::ST_CHECK: begin
        if (chk_stat.done) begin
          if (chk_stat.ok) begin
            div_start = 1'b1;
            state_nxt = srts_pkg::ST_DIV;
          end else begin
            state_nxt = srts_pkg::ST_IDLE;
          end
        end
      end
      srts_pkg::ST_DIV: begin
        if (div_stat.done) begin
          stack_we = 1'b1;
          cnt_nxt  = cnt_r + 6'd1;
          if ((div_quo != '0) &&
              (cnt_r < srts_pkg::CNT_W'(srts_pkg::STACK_DEPTH - 1))) begin
            div_start = 1'b1;
          end else begin
            state_nxt = srts_pkg::ST_EMIT;
          end
        end
      end
      srts_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (sign_r) begin
            out_sym_nxt  = srts_pkg::CH_MINUS;
            out_last_nxt = 1'b0;
            sign_nxt     = 1'b0;
          end else begin
            out_sym_nxt  = srts_pkg::sym_at(alph_r, stack_r[rd_idx]);
            out_last_nxt = (cnt_r == 6'd1);
            cnt_nxt      = cnt_r - 6'd1;
            if (cnt_r == 6'd1) begin
              state_nxt = srts_pkg::ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = srts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srts_pkg::ST_IDLE;
      sign_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sign_r      <= sign_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
    if (in_acc) begin
      mag_r <= in_tdata[31] ? (32'd0 - in_tdata) : in_tdata;
    end
    if (stack_we) begin
      stack_r[cnt_r[srts_pkg::STACK_AW-1:0]] <= div_rem;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;

  `ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r > srts_pkg::CNT_W'(srts_pkg::STACK_DEPTH))
  `ASSERT_PROP(a_div_quiet, clk, rst_n, div_stat.busy |-> (state_r == srts_pkg::ST_DIV))
  `ASSERT_NEVER(a_chk_in_check, clk, rst_n, chk_stat.done && (state_r != srts_pkg::ST_CHECK))
  `ASSERT_PROP(a_emit_has_digit, clk, rst_n, (state_r == srts_pkg::ST_EMIT) |-> (cnt_r != '0))

endmodule

[tb/signed_radix_to_symbols_tb.sv]
// Self-checking testbench for signed_radix_to_symbols: directed table, then random
// alphabets and values, scored against an in-bench predictor of the symbol stream.
// Depends on srts_pkg and the signed_radix_to_symbols RTL.
module signed_radix_to_symbols_tb;
  import srts_pkg::*;

  localparam int BASE_LIMIT      = 16;
  localparam int LEN_CAP         = (BASE_LIMIT < SYM_SLOTS) ? BASE_LIMIT : SYM_SLOTS;
  localparam int SETTLE_CYCLES   = 256;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int RANDOM_ITEMS    = 100;
  localparam int ITEMS_PER_PHASE = 14;
  localparam int DIR_ROWS        = 38;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = CFG_ALEN + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = {CFG_IDX_W{1'b1}};

  typedef enum logic {ROW_CFG, ROW_VALUE} row_kind_t;
  typedef enum int {FAULT_SHORT, FAULT_LONG, FAULT_SIGN, FAULT_RANGE, FAULT_DUP} fault_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
    bit                   typed;
    string                text;
  } dir_row_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
  } sym_beat_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata   = '0;  // [31:0] value
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;        // [7:0] symbol
  logic                 out_tlast;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [31:0]          cfg_wdata  = '0;

  alph_t              cur_words = {RST_SYM_12_15, RST_SYM_8_11, RST_SYM_4_7, RST_SYM_0_3};
  logic [RADIX_W-1:0] cur_len   = RST_ALEN;
  sym_beat_t          pending_syms [$];

  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_VALUE, CFG_SYM_0_3,     32'h0000_0000, 1'b1, "0"},
    '{ROW_VALUE, CFG_SYM_0_3,     32'h8000_0000, 1'b1, "-80000000"},
    '{ROW_VALUE, CFG_SYM_0_3,     32'h7FFF_FFFF, 1'b1, "7fffffff"},
    '{ROW_VALUE, CFG_SYM_0_3,     32'hFFFF_FFFF, 1'b1, "-1"},
    '{ROW_VALUE, CFG_SYM_0_3,     32'h1234_5678, 1'b1, "12345678"},
    '{ROW_VALUE, CFG_SYM_0_3,     32'hFEDC_BA98, 1'b0, ""},
    '{ROW_CFG,   CFG_SYM_0_3,     32'h2B2D_3130, 1'b0, ""},
    '{ROW_CFG,   CFG_ALEN,        32'd2,         1'b0, ""},
    '{ROW_VALUE, CFG_SYM_0_3,     32'h8000_0000, 1'b0, ""},
    '{ROW_VALUE, CFG_SYM_0_3,     32'h7FFF_FFFF, 1'b0, ""},
    '{ROW_VALUE, CFG_SYM_0_3,     32'h0000_0005, 1'b0, ""},
    '{ROW_CFG,   CFG_SYM_0_3,     32'h0041_7E20, 1'b0, ""},
    '{ROW_CFG,   CFG_ALEN,        32'd3,         1'b0, ""},
    '{ROW_CFG,   CFG_UNMAPPED_LO, 32'h0000_0010, 1'b0, ""},
    '{ROW_CFG,   CFG_UNMAPPED_HI, 32'hFFFF_FFFF, 1'b0, ""},
    '{ROW_VALUE, CFG_SYM_0_3,     32'hFFFF_FFF8, 1'b0, ""},
    '{ROW_VALUE, CFG_SYM_0_3,     32'h0000_0000, 1'b0, ""},
    '{ROW_CFG,   CFG_ALEN,        32'd0,         1'b0, ""},
    '{ROW_VALUE, CFG_SYM_0_3,     32'h0000_0001, 1'b1, ""},
    '{ROW_CFG,   CFG_ALEN,        32'd1,         1'b0, ""},
    '{ROW_VALUE, CFG_SYM_0_3,     32'h8000_0000, 1'b1, ""},
    '{ROW_CFG,   CFG_ALEN,        32'd17,        1'b0, ""},
    '{ROW_VALUE, CFG_SYM_0_3,     32'h0000_0001, 1'b1, ""},
    '{ROW_CFG,   CFG_ALEN,        32'd31,        1'b0, ""},
    '{ROW_VALUE, CFG_SYM_0_3,     32'hFFFF_FFFF, 1'b1, ""},
    '{ROW_CFG,   CFG_ALEN,        32'd3,         1'b0, ""},
    '{ROW_CFG,   CFG_SYM_0_3,     32'h002D_3130, 1'b0, ""},
    '{ROW_VALUE, CFG_SYM_0_3,     32'h0000_0001, 1'b1, ""},
    '{ROW_CFG,   CFG_SYM_0_3,     32'h0031_2B30, 1'b0, ""},
    '{ROW_VALUE, CFG_SYM_0_3,     32'h0000_0002, 1'b1, ""},
    '{ROW_CFG,   CFG_SYM_0_3,     32'h001F_3130, 1'b0, ""},
    '{ROW_VALUE, CFG_SYM_0_3,     32'h0000_0003, 1'b1, ""},
    '{ROW_CFG,   CFG_SYM_0_3,     32'h007F_3130, 1'b0, ""},
    '{ROW_VALUE, CFG_SYM_0_3,     32'h0000_0004, 1'b1, ""},
    '{ROW_CFG,   CFG_SYM_0_3,     32'h0030_3130, 1'b0, ""},
    '{ROW_VALUE, CFG_SYM_0_3,     32'hFFFF_FFFE, 1'b1, ""},
    '{ROW_CFG,   CFG_SYM_0_3,     32'h3032_3130, 1'b0, ""},
    '{ROW_VALUE, CFG_SYM_0_3,     32'h0000_0007, 1'b0, ""}
  };

  signed_radix_to_symbols #(
    .MAX_BASE(BASE_LIMIT)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [SYM_W-1:0] symbol_of(input int k);
    return cur_words[k / 4][(k % 4) * 8 +: 8];
  endfunction

  function automatic bit alphabet_ok();
    logic [SYM_W-1:0] c;
    if (cur_len < MIN_LEN || cur_len > LEN_CAP) return 1'b0;
    for (int i = 0; i < cur_len; i++) begin
      c = symbol_of(i);
      if (c < CH_LO || c >= CH_HI || c == CH_PLUS || c == CH_MINUS) return 1'b0;
      for (int j = i + 1; j < cur_len; j++) begin
        if (symbol_of(j) == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic predict_conversion(input logic [31:0] v);
    logic [MAG_W-1:0] mag;
    logic [DIG_W-1:0] digs [STACK_DEPTH];
    int n;
    if (!alphabet_ok()) return;
    mag = v[31] ? -v : v;
    n = 0;
    do begin
      digs[n] = DIG_W'(mag % cur_len);
      n++;
      mag = mag / cur_len;
    end while (mag != 0 && n < STACK_DEPTH);
    if (v[31]) pending_syms.push_back(sym_beat_t'{CH_MINUS, 1'b0});
    for (int i = n - 1; i >= 0; i--) begin
      pending_syms.push_back(sym_beat_t'{symbol_of(digs[i]), i == 0});
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx < CFG_ALEN) cur_words[idx[1:0]] = data;
    else if (idx == CFG_ALEN) cur_len = data[RADIX_W-1:0];
  endtask

  task automatic send_value(input logic [31:0] v, input bit typed, input string text);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    if (typed) begin
      for (int i = 0; i < text.len(); i++) begin
        pending_syms.push_back(sym_beat_t'{text[i], i == text.len() - 1});
      end
    end else begin
      predict_conversion(v);
    end
  endtask

  // hold off config until the converter is idle, even after a silent item
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_syms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_random_alphabet(input bit keep_valid);
    logic [SYM_W-1:0]   syms [SYM_SLOTS];
    logic [RADIX_W-1:0] len;
    int                 k;
    bit                 clash;
    fault_t             fault;
    case ($urandom_range(9))
      0:       len = MIN_LEN;
      1:       len = RADIX_W'(LEN_CAP);
      default: len = RADIX_W'($urandom_range(LEN_CAP, MIN_LEN));
    endcase
    foreach (syms[i]) syms[i] = SYM_W'($urandom);
    for (int i = 0; i < len; i++) begin
      do begin
        syms[i] = SYM_W'($urandom_range(CH_HI - 1, CH_LO));
        clash = (syms[i] == CH_PLUS) || (syms[i] == CH_MINUS);
        for (int j = 0; j < i; j++) begin
          if (syms[j] == syms[i]) clash = 1'b1;
        end
      end while (clash);
    end
    if (!keep_valid) begin
      fault = fault_t'($urandom_range(FAULT_DUP, FAULT_SHORT));
      k = $urandom_range(len - 1, 1);
      case (fault)
        FAULT_SHORT: len = RADIX_W'($urandom_range(MIN_LEN - 1, 0));
        FAULT_LONG:  len = RADIX_W'($urandom_range(2 ** RADIX_W - 1, LEN_CAP + 1));
        FAULT_SIGN:  syms[k] = $urandom_range(1) ? CH_PLUS : CH_MINUS;
        FAULT_RANGE: syms[k] = $urandom_range(1) ? SYM_W'($urandom_range(CH_LO - 1, 0))
                                                 : SYM_W'($urandom_range(255, CH_HI));
        FAULT_DUP:   syms[k] = syms[$urandom_range(k - 1, 0)];
        default: ;
      endcase
    end
    for (int w = 0; w < NUM_WORDS; w++) begin
      cfg_write(CFG_SYM_0_3 + CFG_IDX_W'(w),
                {syms[4 * w + 3], syms[4 * w + 2], syms[4 * w + 1], syms[4 * w]});
    end
    cfg_write(CFG_ALEN, 32'(len));
    cfg_we <= 1'b0;
  endtask

  task automatic log_mismatch(input string what, input sym_beat_t want, input sym_beat_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected symbol %h last %b, got symbol %h last %b",
               what, want.sym, want.last, got.sym, got.last);
    end
  endtask

  always @(posedge clk) begin
    sym_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_syms.size() == 0) begin
        log_mismatch("unexpected transaction", sym_beat_t'('0), {out_tdata, out_tlast});
      end else begin
        want = pending_syms.pop_front();
        if (out_tdata != want.sym || out_tlast != want.last) begin
          log_mismatch("wrong field", want, {out_tdata, out_tlast});
        end
      end
    end
    if (hold_seen != hold_token) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] v;
    bit          in_cfg;
    bit          good;
    int          phase;
    int          valid_sent;
    in_cfg     = 1'b0;
    phase      = 0;
    valid_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        if (!in_cfg) begin
          wait_for_drain();
          in_cfg = 1'b1;
        end
        cfg_write(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        if (in_cfg) begin
          cfg_we <= 1'b0;
          in_cfg = 1'b0;
        end
        send_value(dir_rows[r].data, dir_rows[r].typed, dir_rows[r].text);
      end
    end

    while (valid_sent < RANDOM_ITEMS) begin
      wait_for_drain();
      good = (phase % 6) != 5;
      program_random_alphabet(good);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (phase == 0) hold_token++;
      for (int i = 0; i < (good ? ITEMS_PER_PHASE : 3); i++) begin
        case ($urandom_range(9))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0000_0000;
          3:       v = -32'($urandom_range(50, 1));
          4, 5:    v = $urandom_range(300);
          default: v = $urandom;
        endcase
        send_value(v, 1'b0, "");
      end
      if (good) valid_sent += ITEMS_PER_PHASE;
      phase++;
    end
    wait_for_drain();

    if (mismatches == 0 && pending_syms.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
